// File: rtl/optical_symbol_window_decoder_core_macros.svh
// Assertion macros for the optical symbol window decoder checker.
// Used by osw_checker.sv; relies on i_clk and i_rst_n in the including scope.
`ifndef OPTICAL_SYMBOL_WINDOW_DECODER_CORE_MACROS_SVH
`define OPTICAL_SYMBOL_WINDOW_DECODER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OSW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("osw assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define OSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("osw assertion failed");

// Consequent must hold in the cycle after reset is applied.
`define OSW_ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("osw assertion failed after reset");

`endif

// File: rtl/osw_pkg.sv
// Shared types and constants for the optical symbol window decoder.
// No dependencies.
package osw_pkg;

    typedef enum logic [1:0] {
        SYM_LOW      = 2'd0,
        SYM_HIGH     = 2'd1,
        SYM_SENTINEL = 2'd2,
        SYM_MISSING  = 2'd3
    } t_symbol;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_FRAME = 2'd1,
        EV_ABORT = 2'd2
    } t_event_kind;

    typedef struct packed {
        t_event_kind event_kind;
        logic        data_bit;
    } t_evt;

    localparam int          WIN_LEN_WIDTH = 8;
    localparam logic [7:0] WIN_LEN_RESET = 8'd8;

endpackage

// File: rtl/osw_sym_if.sv
// Input channel carrying one detected symbol per transfer.
// Depends on osw_pkg.
interface osw_sym_if import osw_pkg::*; ();
    logic    valid;
    logic    ready;
    t_symbol symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

// File: rtl/osw_evt_if.sv
// Output channel carrying one decoder event per transfer.
// Depends on osw_pkg.
interface osw_evt_if import osw_pkg::*; ();
    logic        valid;
    logic        ready;
    t_event_kind event_kind;
    logic        data_bit;

    modport source (output valid, output event_kind, output data_bit, input ready);
    modport sink   (input valid, input event_kind, input data_bit, output ready);
endinterface

// File: rtl/optical_symbol_window_decoder_core.sv
// Optical symbol window decoder: phase machine, window counters, output queue.
// Depends on osw_pkg, osw_sym_if, osw_evt_if.
//
// Usage:
//   i_sym  : one symbol per transfer (low, high, sentinel, missing).
//   o_evt  : zero or one event per symbol: data bit, frame complete or abort.
//   i_cfg_we / i_cfg_wdata : window length, written while the block is idle.
// Each accepted symbol updates the phase and the running counters in the
// cycle it is accepted; an event it causes is registered into the queue
// that drives o_evt. One symbol is accepted every cycle while the sink keeps
// up: the counters and the vote are a single registered step.
// Events go through a two-entry output queue, so the block keeps taking
// symbols while one event waits. When the sink stalls and both entries are
// full, i_sym.ready drops until an event is transferred.
// Reset (synchronous, active low) returns to warmup, clears the counters and
// the queue, and sets the window length to 8.
module optical_symbol_window_decoder_core
    import osw_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [WIN_LEN_WIDTH-1:0] i_cfg_wdata,
    osw_sym_if.sink                  i_sym,
    osw_evt_if.source                o_evt
);

    localparam int LIM_WIDTH = (COUNT_WIDTH > WIN_LEN_WIDTH) ? COUNT_WIDTH : WIN_LEN_WIDTH;
    localparam int SUM_WIDTH = COUNT_WIDTH + 2;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    typedef enum logic [1:0] {
        PH_WARMUP     = 2'd0,
        PH_DETECTED   = 2'd1,
        PH_PROCESSING = 2'd2
    } t_phase;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_ONE;
    endfunction

    logic [WIN_LEN_WIDTH-1:0] r_win_len;
    t_phase                   r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]   r_fill, n_fill;
    logic [COUNT_WIDTH-1:0]   r_low, n_low;
    logic [COUNT_WIDTH-1:0]   r_high, n_high;
    logic [COUNT_WIDTH-1:0]   r_sent, n_sent;
    logic [COUNT_WIDTH-1:0]   r_miss, n_miss;
    t_evt                     r_q0, n_q0;
    t_evt                     r_q1, n_q1;
    logic [1:0]               r_cnt, n_cnt;

    logic                     accept;
    logic                     pop;
    logic                     push;
    t_evt                     res;
    logic [COUNT_WIDTH-1:0]   c_fill, c_low, c_high, c_sent, c_miss;
    logic [LIM_WIDTH-1:0]     lim_wl, lim_max, limit;
    logic [SUM_WIDTH-1:0]     others;

    assign i_sym.ready      = (r_cnt != 2'd2);
    assign accept           = i_sym.valid && i_sym.ready;
    assign o_evt.valid      = (r_cnt != 2'd0);
    assign o_evt.event_kind = r_q0.event_kind;
    assign o_evt.data_bit   = r_q0.data_bit;
    assign pop              = o_evt.valid && o_evt.ready;

    assign lim_wl  = LIM_WIDTH'(r_win_len);
    assign lim_max = LIM_WIDTH'(COUNT_MAX);
    assign limit   = (lim_wl < lim_max) ? lim_wl : lim_max;

    // running counts including the current symbol
    always_comb begin
        c_fill = sat_inc(r_fill);
        c_low  = r_low;
        c_high = r_high;
        c_sent = r_sent;
        c_miss = r_miss;
        case (i_sym.symbol)
            SYM_LOW:      c_low  = sat_inc(r_low);
            SYM_HIGH:     c_high = sat_inc(r_high);
            SYM_SENTINEL: c_sent = sat_inc(r_sent);
            default:      c_miss = sat_inc(r_miss);
        endcase
    end

    assign others = SUM_WIDTH'(c_low) + SUM_WIDTH'(c_high) + SUM_WIDTH'(c_sent);

    always_comb begin
        n_phase             = r_phase;
        n_fill              = r_fill;
        n_low               = r_low;
        n_high              = r_high;
        n_sent              = r_sent;
        n_miss              = r_miss;
        push                = 1'b0;
        res.event_kind      = EV_DATA;
        res.data_bit        = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_DETECTED: begin
                    if (i_sym.symbol == SYM_LOW || i_sym.symbol == SYM_HIGH) begin
                        n_fill  = COUNT_ONE;
                        n_low   = (i_sym.symbol == SYM_LOW) ? COUNT_ONE : '0;
                        n_high  = (i_sym.symbol == SYM_HIGH) ? COUNT_ONE : '0;
                        n_sent  = '0;
                        n_miss  = '0;
                        n_phase = PH_PROCESSING;
                    end
                end
                PH_PROCESSING: begin
                    n_fill = c_fill;
                    n_low  = c_low;
                    n_high = c_high;
                    n_sent = c_sent;
                    n_miss = c_miss;
                    if (LIM_WIDTH'(c_fill) >= limit) begin
                        push   = 1'b1;
                        n_fill = '0;
                        n_low  = '0;
                        n_high = '0;
                        n_sent = '0;
                        n_miss = '0;
                        if (SUM_WIDTH'(c_miss) > others) begin
                            res.event_kind = EV_ABORT;
                            n_phase        = PH_WARMUP;
                        end else if (c_sent > c_low && c_sent > c_high) begin
                            res.event_kind = EV_FRAME;
                            n_phase        = PH_DETECTED;
                        end else begin
                            res.data_bit = (c_high > c_low);
                        end
                    end
                end
                default: begin
                    if (i_sym.symbol == SYM_SENTINEL) begin
                        n_phase = PH_DETECTED;
                    end
                end
            endcase
        end
    end

    // two-entry output queue, head in r_q0
    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt;
        case (r_cnt)
            2'd0: begin
                if (push) begin
                    n_q0  = res;
                    n_cnt = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    n_q0 = res;
                end else if (push) begin
                    n_q1  = res;
                    n_cnt = 2'd2;
                end else if (pop) begin
                    n_cnt = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    n_q0  = r_q1;
                    n_cnt = 2'd1;
                end
            end
            default: begin
                n_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WIN_LEN_RESET;
            r_phase   <= PH_WARMUP;
            r_fill    <= '0;
            r_low     <= '0;
            r_high    <= '0;
            r_sent    <= '0;
            r_miss    <= '0;
            r_cnt     <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_win_len <= i_cfg_wdata;
            end
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_low   <= n_low;
            r_high  <= n_high;
            r_sent  <= n_sent;
            r_miss  <= n_miss;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

// File: rtl/osw_checker.sv
// Port-level checker for the optical symbol window decoder, with its bind.
// Depends on osw_pkg and optical_symbol_window_decoder_core_macros.svh.
`include "optical_symbol_window_decoder_core_macros.svh"

module osw_checker
    import osw_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_sym_valid,
    input logic        i_sym_ready,
    input logic        i_evt_valid,
    input logic        i_evt_ready,
    input t_event_kind i_event_kind,
    input logic        i_data_bit
);

    `OSW_ASSERT_NEXT(a_evt_hold, i_evt_valid && !i_evt_ready, i_evt_valid && $stable(i_event_kind) && $stable(i_data_bit))
    `OSW_ASSERT_SAME(a_kind_legal, i_evt_valid, i_event_kind == EV_DATA || i_event_kind == EV_FRAME || i_event_kind == EV_ABORT)
    `OSW_ASSERT_SAME(a_bit_zero, i_evt_valid && i_event_kind != EV_DATA, !i_data_bit)
    `OSW_ASSERT_SAME(a_full_valid, i_sym_valid && !i_sym_ready, i_evt_valid)
    `OSW_ASSERT_RST(a_rst_empty, !i_evt_valid && i_sym_ready)

endmodule

bind optical_symbol_window_decoder_core osw_checker u_osw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_sym_valid  (i_sym.valid),
    .i_sym_ready  (i_sym.ready),
    .i_evt_valid  (o_evt.valid),
    .i_evt_ready  (o_evt.ready),
    .i_event_kind (o_evt.event_kind),
    .i_data_bit   (o_evt.data_bit)
);

// File: bench/tb_optical_symbol_window_decoder_core.sv
// Testbench for optical_symbol_window_decoder_core: directed and random symbol streams
// under several window lengths and flow-control patterns, checked in order against a vote predictor.
// Depends on osw_pkg, osw_sym_if, osw_evt_if and the core RTL.
module tb_optical_symbol_window_decoder_core;
    import osw_pkg::*;

    localparam int COUNT_WIDTH = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        LOCK_WARMUP = 2'd0,
        LOCK_SEEN   = 2'd1,
        LOCK_VOTING = 2'd2
    } t_lock;

    typedef enum int {MIX_DATA, MIX_SENTINEL, MIX_MISSING, MIX_NOISE} t_mix;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [WIN_LEN_WIDTH-1:0] i_cfg_wdata;

    osw_sym_if sym_if ();
    osw_evt_if evt_if ();

    optical_symbol_window_decoder_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sym       (sym_if),
        .o_evt       (evt_if)
    );

    t_symbol pending_symbols [$];
    t_evt    expected_events [$];

    // predictor state
    logic [WIN_LEN_WIDTH-1:0] win_len;
    t_lock                    lock;
    logic [COUNT_WIDTH-1:0]   n_fill, n_low, n_high, n_sent, n_miss;

    int   idle_pct = 0;
    int   stall_pct = 0;
    logic hold_armed = 1'b0;
    logic rx_hold = 1'b0;

    int errors = 0;
    int cycle = 0;
    int symbols_sent = 0;
    int data_events = 0;
    int frame_events = 0;
    int abort_events = 0;
    int input_stall_cycles = 0;

    t_symbol opening_run [22];
    t_symbol short_run [5];
    logic [WIN_LEN_WIDTH-1:0] mid_len_a, mid_len_b;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [COUNT_WIDTH-1:0] sat_bump(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic clear_tallies();
        n_fill = '0;
        n_low  = '0;
        n_high = '0;
        n_sent = '0;
        n_miss = '0;
    endtask

    task automatic queue_symbol(input t_symbol s);
        pending_symbols = {pending_symbols, s};
    endtask

    task automatic tally(input t_symbol s);
        n_fill = sat_bump(n_fill);
        case (s)
            SYM_LOW:      n_low  = sat_bump(n_low);
            SYM_HIGH:     n_high = sat_bump(n_high);
            SYM_SENTINEL: n_sent = sat_bump(n_sent);
            default:      n_miss = sat_bump(n_miss);
        endcase
    endtask

    // advance the phase machine by one symbol, queue the event it causes
    task automatic vote_on_symbol(input t_symbol s);
        t_evt ev;
        case (lock)
            LOCK_SEEN: begin
                if (s == SYM_LOW || s == SYM_HIGH) begin
                    clear_tallies();
                    tally(s);
                    lock = LOCK_VOTING;
                end
            end
            LOCK_VOTING: begin
                tally(s);
                if (n_fill >= win_len) begin
                    ev.data_bit = 1'b0;
                    if (int'(n_miss) > int'(n_low) + int'(n_high) + int'(n_sent)) begin
                        ev.event_kind = EV_ABORT;
                        lock = LOCK_WARMUP;
                    end else if (n_sent > n_low && n_sent > n_high) begin
                        ev.event_kind = EV_FRAME;
                        lock = LOCK_SEEN;
                    end else begin
                        ev.event_kind = EV_DATA;
                        ev.data_bit = (n_high > n_low);
                    end
                    expected_events = {expected_events, ev};
                    clear_tallies();
                end
            end
            default: begin
                if (s == SYM_SENTINEL) lock = LOCK_SEEN;
            end
        endcase
    endtask

    function automatic t_symbol pick_symbol(input t_mix mix, input int high_pct);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_DATA: begin
                if (r < 88) return ($urandom_range(99) < high_pct) ? SYM_HIGH : SYM_LOW;
            end
            MIX_SENTINEL: begin
                if (r < 60) return SYM_SENTINEL;
            end
            MIX_MISSING: begin
                if (r < 75) return SYM_MISSING;
            end
            default: ;
        endcase
        return t_symbol'($urandom_range(3));
    endfunction

    task automatic add_window(input int n, input t_mix mix);
        int high_pct;
        high_pct = $urandom_range(100);
        repeat (n) queue_symbol(pick_symbol(mix, high_pct));
    endtask

    // frames: optional noise burst, sentinel, opening bit, then one to four windows of mixed content
    task automatic gen_traffic(input int n);
        int   made;
        int   span;
        int   r;
        t_mix mix;
        made = 0;
        span = (win_len == 0) ? 1 : win_len;
        while (made < n) begin
            if ($urandom_range(9) == 0) begin
                r = $urandom_range(3, 1);
                add_window(r, MIX_NOISE);
                made += r;
            end
            queue_symbol(SYM_SENTINEL);
            queue_symbol($urandom_range(1) ? SYM_HIGH : SYM_LOW);
            made += 2;
            repeat ($urandom_range(4, 1)) begin
                r = $urandom_range(99);
                mix = (r < 65) ? MIX_DATA : (r < 78) ? MIX_SENTINEL :
                      (r < 90) ? MIX_MISSING : MIX_NOISE;
                add_window(span, mix);
                made += span;
            end
        end
    endtask

    task automatic settle();
        while (pending_symbols.size() != 0 || expected_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [WIN_LEN_WIDTH-1:0] len);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_len = len;
    endtask

    task automatic flag_error(input string what);
        errors++;
        if (errors <= MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycle, what);
    endtask

    // symbol driver
    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            sym_if.valid  <= 1'b0;
            sym_if.symbol <= SYM_LOW;
        end else begin
            offer = sym_if.valid;
            if (sym_if.valid && !sym_if.ready) input_stall_cycles++;
            if (sym_if.valid && sym_if.ready) begin
                vote_on_symbol(sym_if.symbol);
                void'(pending_symbols.pop_front());
                symbols_sent++;
                offer = 1'b0;
            end
            if (!offer && pending_symbols.size() != 0)
                offer = ($urandom_range(99) >= idle_pct);
            sym_if.valid <= offer;
            if (offer) sym_if.symbol <= pending_symbols[0];
        end
    end

    // event monitor and checker
    always @(posedge i_clk) begin
        t_evt want;
        if (!i_rst_n) begin
            evt_if.ready <= 1'b0;
        end else begin
            if (evt_if.valid && evt_if.ready) begin
                case (evt_if.event_kind)
                    EV_DATA:  data_events++;
                    EV_FRAME: frame_events++;
                    default:  abort_events++;
                endcase
                if (expected_events.size() == 0) begin
                    flag_error($sformatf("unexpected event kind %0d bit %0b",
                                         evt_if.event_kind, evt_if.data_bit));
                end else begin
                    want = expected_events.pop_front();
                    if (evt_if.event_kind !== want.event_kind ||
                        evt_if.data_bit !== want.data_bit)
                        flag_error($sformatf("expected %s bit %0b, got kind %0d bit %0b",
                                             want.event_kind.name(), want.data_bit,
                                             evt_if.event_kind, evt_if.data_bit));
                end
            end
            evt_if.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    // long receiver hold-off so the output queue fills and the input stalls
    initial begin
        wait (hold_armed);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle++;
        if (cycle > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle, expected_events.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        sym_if.valid  = 1'b0;
        sym_if.symbol = SYM_LOW;
        evt_if.ready  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_rst_n       = 1'b0;
        win_len       = WIN_LEN_RESET;
        lock          = LOCK_WARMUP;
        clear_tallies();
        opening_run = '{SYM_LOW, SYM_MISSING, SYM_HIGH, SYM_SENTINEL,
                        SYM_SENTINEL, SYM_MISSING, SYM_HIGH,
                        SYM_HIGH, SYM_LOW, SYM_HIGH, SYM_SENTINEL,
                        SYM_MISSING, SYM_HIGH, SYM_LOW,
                        SYM_LOW, SYM_HIGH, SYM_SENTINEL, SYM_SENTINEL,
                        SYM_SENTINEL, SYM_LOW, SYM_HIGH, SYM_SENTINEL};
        short_run = '{SYM_LOW, SYM_HIGH, SYM_HIGH, SYM_SENTINEL, SYM_MISSING};
        mid_len_a = WIN_LEN_WIDTH'($urandom_range(12, 2));
        mid_len_b = WIN_LEN_WIDTH'($urandom_range(12, 2));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset window length: warmup, detected, data and frame windows
        foreach (opening_run[i]) queue_symbol(opening_run[i]);
        settle();

        // one-symbol window
        set_window(8'd1);
        foreach (short_run[i]) queue_symbol(short_run[i]);
        gen_traffic(80);
        settle();

        set_window(8'd0);
        idle_pct <= 58;
        gen_traffic(100);
        settle();

        set_window(mid_len_a);
        idle_pct  <= 0;
        stall_pct <= 58;
        gen_traffic(120);
        settle();

        set_window(mid_len_b);
        idle_pct  <= 17;
        stall_pct <= 17;
        gen_traffic(120);
        settle();

        // back-pressure: sink holds off while the source keeps offering
        set_window(8'd1);
        idle_pct   <= 0;
        stall_pct  <= 0;
        hold_armed <= 1'b1;
        gen_traffic(100);
        settle();

        // longest window: one data window, then one mostly missing
        set_window(8'd255);
        queue_symbol(SYM_SENTINEL);
        queue_symbol(SYM_LOW);
        add_window(254, MIX_DATA);
        add_window(255, MIX_MISSING);
        settle();

        $display("covered %0d symbols over window lengths 8, 1, 0, %0d, %0d, 255",
                 symbols_sent, mid_len_a, mid_len_b);
        $display("events: %0d data, %0d frame, %0d abort; input stalled %0d cycles",
                 data_events, frame_events, abort_events, input_stall_cycles);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
